// File: sv/mtfrd_pkg.sv
// ----------------------------------------------------------------------------
// mtfrd_pkg
// Shared types and constants of the multitouch finger report decoder.
// ----------------------------------------------------------------------------
package mtfrd_pkg;

  localparam int unsigned FieldW = 8;
  localparam int unsigned IndexW = 4;
  localparam int unsigned PosW   = 12;
  localparam int unsigned WidthW = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [PosW-1:0] PosOffset = 12'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTouchPresent = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIntrMask     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxX         = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxY         = 2'd3;

  // finger slot status codes
  localparam logic [1:0] StatusAbsent  = 2'd0;
  localparam logic [1:0] StatusPresent = 2'd1;

  // finger phase codes
  localparam logic [1:0] PhaseIdle    = 2'd0;
  localparam logic [1:0] PhaseRelease = 2'd1;
  localparam logic [1:0] PhaseTouch   = 2'd2;

  // one pending result, raw bytes still packed
  typedef struct packed {
    logic              has_contact;
    logic [IndexW-1:0] finger_index;
    logic [FieldW-1:0] pressure;
    logic [FieldW-1:0] x_high;
    logic [FieldW-1:0] y_high;
    logic [FieldW-1:0] xy_low;
    logic [FieldW-1:0] width_pair;
    logic              last_finger;
  } entry_t;

endpackage

// File: sv/mtfrd_front.sv
// ----------------------------------------------------------------------------
// mtfrd_front
// Accepts finger records, filters them by the interrupt mask, keeps the
// per-finger touch phase and pushes records that produce a result.
// ----------------------------------------------------------------------------
module mtfrd_front #(
  parameter int unsigned MaxFingers = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mtfrd_pkg::FieldW-1:0]  interrupt_status_i,
  input  logic [mtfrd_pkg::IndexW-1:0]  finger_index_i,
  input  logic [1:0]                    finger_status_i,
  input  logic [mtfrd_pkg::FieldW-1:0]  x_high_i,
  input  logic [mtfrd_pkg::FieldW-1:0]  y_high_i,
  input  logic [mtfrd_pkg::FieldW-1:0]  xy_low_i,
  input  logic [mtfrd_pkg::FieldW-1:0]  width_pair_i,
  input  logic [mtfrd_pkg::FieldW-1:0]  pressure_i,
  input  logic                          last_finger_i,
  input  logic                          touch_present_i,
  input  logic [mtfrd_pkg::FieldW-1:0]  irq_mask_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output mtfrd_pkg::entry_t             entry_o
);
  import mtfrd_pkg::*;

  logic [1:0] phase_q [MaxFingers];
  logic [1:0] cur_phase;
  logic [1:0] mid_phase;
  logic [1:0] new_phase;
  logic       accept;
  logic       decode_en;
  logic       in_range;
  logic       contact;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign decode_en  = touch_present_i && ((interrupt_status_i & irq_mask_i) != '0);
  assign in_range   = {1'b0, finger_index_i} < (IndexW+1)'(MaxFingers);

  always_comb begin
    cur_phase = PhaseIdle;
    for (int k = 0; k < MaxFingers; k++) begin
      if (finger_index_i == IndexW'(k)) begin
        cur_phase = phase_q[k];
      end
    end
  end

  always_comb begin
    if (finger_status_i == StatusPresent) begin
      mid_phase = PhaseTouch;
    end else if (finger_status_i == StatusAbsent && cur_phase != PhaseIdle) begin
      mid_phase = PhaseRelease;
    end else begin
      mid_phase = cur_phase;
    end
    contact   = in_range && (mid_phase == PhaseRelease || mid_phase == PhaseTouch);
    new_phase = (mid_phase == PhaseRelease) ? PhaseIdle : mid_phase;
  end

  for (genvar k = 0; k < MaxFingers; k++) begin : g_phase
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[k] <= PhaseIdle;
      end else if (accept && decode_en && in_range && finger_index_i == IndexW'(k)) begin
        phase_q[k] <= new_phase;
      end
    end
  end

  assign push_o = accept && decode_en && (contact || last_finger_i);

  always_comb begin
    entry_o.has_contact  = contact;
    entry_o.finger_index = finger_index_i;
    entry_o.pressure     = pressure_i;
    entry_o.x_high       = x_high_i;
    entry_o.y_high       = y_high_i;
    entry_o.xy_low       = xy_low_i;
    entry_o.width_pair   = width_pair_i;
    entry_o.last_finger  = last_finger_i;
  end

endmodule

// File: sv/mtfrd_queue.sv
// ----------------------------------------------------------------------------
// mtfrd_queue
// Two-entry queue between the record front end and the report back end.
// ----------------------------------------------------------------------------
module mtfrd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mtfrd_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output mtfrd_pkg::entry_t entry_o
);
  import mtfrd_pkg::*;

  entry_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: sv/mtfrd_back.sv
// ----------------------------------------------------------------------------
// mtfrd_back
// Decodes queued records into contact and frame-end reports and holds them in
// the output register until taken.
// ----------------------------------------------------------------------------
module mtfrd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  mtfrd_pkg::entry_t            entry_i,
  output logic                         pop_o,
  input  logic [mtfrd_pkg::PosW-1:0]   max_x_i,
  input  logic [mtfrd_pkg::PosW-1:0]   max_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         has_contact_o,
  output logic [mtfrd_pkg::IndexW-1:0] tracking_id_o,
  output logic [mtfrd_pkg::FieldW-1:0] contact_pressure_o,
  output logic [mtfrd_pkg::WidthW-1:0] contact_width_o,
  output logic [mtfrd_pkg::PosW-1:0]   position_x_o,
  output logic [mtfrd_pkg::PosW-1:0]   position_y_o,
  output logic                         frame_end_o
);
  import mtfrd_pkg::*;

  function automatic logic [PosW-1:0] clamp_pos(logic [PosW-1:0] raw,
                                                logic [PosW-1:0] maxv);
    logic [PosW-1:0] shifted;
    shifted = raw - PosOffset;
    if (raw < PosOffset) begin
      return '0;
    end else if (shifted > maxv) begin
      return maxv;
    end
    return shifted;
  endfunction

  logic              out_valid_q;
  logic              has_contact_q, has_contact_d;
  logic [IndexW-1:0] tracking_id_q, tracking_id_d;
  logic [FieldW-1:0] pressure_q, pressure_d;
  logic [WidthW-1:0] width_q, width_d;
  logic [PosW-1:0]   pos_x_q, pos_x_d;
  logic [PosW-1:0]   pos_y_q, pos_y_d;
  logic              frame_end_q, frame_end_d;
  logic [PosW-1:0]   raw_x;
  logic [PosW-1:0]   raw_y;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    raw_x = {entry_i.x_high, entry_i.xy_low[3:0]};
    raw_y = {entry_i.y_high, entry_i.xy_low[7:4]};
    has_contact_d = entry_i.has_contact;
    frame_end_d   = entry_i.last_finger;
    if (entry_i.has_contact) begin
      tracking_id_d = entry_i.finger_index;
      pressure_d    = entry_i.pressure;
      width_d       = {1'b0, entry_i.width_pair[3:0]} + {1'b0, entry_i.width_pair[7:4]};
      pos_x_d       = clamp_pos(raw_x, max_x_i);
      pos_y_d       = clamp_pos(raw_y, max_y_i);
    end else begin
      // frame end without a contact carries zero fields
      tracking_id_d = '0;
      pressure_d    = '0;
      width_d       = '0;
      pos_x_d       = '0;
      pos_y_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      has_contact_q <= has_contact_d;
      tracking_id_q <= tracking_id_d;
      pressure_q    <= pressure_d;
      width_q       <= width_d;
      pos_x_q       <= pos_x_d;
      pos_y_q       <= pos_y_d;
      frame_end_q   <= frame_end_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign has_contact_o      = has_contact_q;
  assign tracking_id_o      = tracking_id_q;
  assign contact_pressure_o = pressure_q;
  assign contact_width_o    = width_q;
  assign position_x_o       = pos_x_q;
  assign position_y_o       = pos_y_q;
  assign frame_end_o        = frame_end_q;

endmodule

// File: sv/multitouch_finger_report_decoder.sv
// ----------------------------------------------------------------------------
// multitouch_finger_report_decoder
// Decodes finger records of a touch frame into contact and frame-end reports.
// ----------------------------------------------------------------------------
// The block takes one finger record per clock cycle while the queue is not
// full, and gives at most one report per record. A record is checked against
// the interrupt mask and the finger's touch phase is read and rewritten in the
// same cycle, which sets the rate of one record per cycle. Records that yield a
// report go into a two-entry queue; the back end decodes position and width
// and loads the output register once it is free. The queue and the output
// register let the input keep flowing while a report waits to be taken.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i; the
// user must write only while no record is in flight; the block does not check.
module multitouch_finger_report_decoder #(
  parameter int unsigned MAX_FINGERS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mtfrd_pkg::FieldW-1:0]   interrupt_status_i,
  input  logic [mtfrd_pkg::IndexW-1:0]   finger_index_i,
  input  logic [1:0]                     finger_status_i,
  input  logic [mtfrd_pkg::FieldW-1:0]   x_high_i,
  input  logic [mtfrd_pkg::FieldW-1:0]   y_high_i,
  input  logic [mtfrd_pkg::FieldW-1:0]   xy_low_i,
  input  logic [mtfrd_pkg::FieldW-1:0]   width_pair_i,
  input  logic [mtfrd_pkg::FieldW-1:0]   pressure_i,
  input  logic                           last_finger_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           has_contact_o,
  output logic [mtfrd_pkg::IndexW-1:0]   tracking_id_o,
  output logic [mtfrd_pkg::FieldW-1:0]   contact_pressure_o,
  output logic [mtfrd_pkg::WidthW-1:0]   contact_width_o,
  output logic [mtfrd_pkg::PosW-1:0]     position_x_o,
  output logic [mtfrd_pkg::PosW-1:0]     position_y_o,
  output logic                           frame_end_o,
  input  logic                           cfg_we_i,
  input  logic [mtfrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mtfrd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import mtfrd_pkg::*;

  logic            touch_present_q;
  logic [FieldW-1:0] irq_mask_q;
  logic [PosW-1:0] max_x_q;
  logic [PosW-1:0] max_y_q;

  logic   push;
  logic   q_full;
  logic   q_valid;
  logic   pop;
  entry_t push_entry;
  entry_t head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_present_q <= 1'b1;
      irq_mask_q      <= '0;
      max_x_q         <= '1;
      max_y_q         <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTouchPresent: touch_present_q <= cfg_wdata_i[0];
        CfgIntrMask:     irq_mask_q      <= cfg_wdata_i[FieldW-1:0];
        CfgMaxX:         max_x_q         <= cfg_wdata_i[PosW-1:0];
        CfgMaxY:         max_y_q         <= cfg_wdata_i[PosW-1:0];
        default: begin
        end
      endcase
    end
  end

  mtfrd_front #(
    .MaxFingers(MAX_FINGERS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .interrupt_status_i (interrupt_status_i),
    .finger_index_i     (finger_index_i),
    .finger_status_i    (finger_status_i),
    .x_high_i           (x_high_i),
    .y_high_i           (y_high_i),
    .xy_low_i           (xy_low_i),
    .width_pair_i       (width_pair_i),
    .pressure_i         (pressure_i),
    .last_finger_i      (last_finger_i),
    .touch_present_i    (touch_present_q),
    .irq_mask_i         (irq_mask_q),
    .q_full_i           (q_full),
    .push_o             (push),
    .entry_o            (push_entry)
  );

  mtfrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  mtfrd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .entry_i            (head_entry),
    .pop_o              (pop),
    .max_x_i            (max_x_q),
    .max_y_i            (max_y_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .has_contact_o      (has_contact_o),
    .tracking_id_o      (tracking_id_o),
    .contact_pressure_o (contact_pressure_o),
    .contact_width_o    (contact_width_o),
    .position_x_o       (position_x_o),
    .position_y_o       (position_y_o),
    .frame_end_o        (frame_end_o)
  );

  // a report without contact is a bare frame end with cleared fields
  a_bare_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_contact_o |-> frame_end_o && tracking_id_o == '0 &&
      contact_pressure_o == '0 && contact_width_o == '0 &&
      position_x_o == '0 && position_y_o == '0)
    else $error("frame end report carries stale fields");

  // contact reports only come from tracked slots
  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_contact_o |-> {1'b0, tracking_id_o} < (IndexW+1)'(MAX_FINGERS))
    else $error("contact report for untracked slot");

  // width is the sum of two nibbles
  a_width_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_contact_o |-> contact_width_o <= WidthW'(30))
    else $error("contact width out of range");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multitouch finger report decoder.
// ----------------------------------------------------------------------------
// Finger records are queued by the stimulus process and fed by a clocked
// driver; every accepted record runs through a local decoder model that keeps
// its own per-slot touch phases and register copies and queues the report it
// should cause. A clocked monitor compares each report beat field by field
// with the oldest queued report. Registers change only while the block is
// drained. Both sides idle in random bursts, the receiver once holds off long
// enough to back up the block, and the final stretch runs without idling.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtfrd_pkg::*;

  localparam int NumSlots     = 10;
  localparam int LongHold     = 80;
  localparam int SettleCycles = 4;
  localparam int QuietLimit   = 3000;

  typedef struct packed {
    logic [FieldW-1:0] intr;
    logic [IndexW-1:0] idx;
    logic [1:0]        status;
    logic [FieldW-1:0] x_high;
    logic [FieldW-1:0] y_high;
    logic [FieldW-1:0] xy_low;
    logic [FieldW-1:0] width_pair;
    logic [FieldW-1:0] pressure;
    logic              last_finger;
  } finger_rec_t;

  typedef struct packed {
    logic              has_contact;
    logic [IndexW-1:0] tracking_id;
    logic [FieldW-1:0] pressure;
    logic [WidthW-1:0] width;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic              frame_end;
  } finger_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready_o;
  finger_rec_t         rec_drv = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  logic                has_contact_o;
  logic [IndexW-1:0]   tracking_id_o;
  logic [FieldW-1:0]   contact_pressure_o;
  logic [WidthW-1:0]   contact_width_o;
  logic [PosW-1:0]     position_x_o;
  logic [PosW-1:0]     position_y_o;
  logic                frame_end_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // local copies of the registers and the per-slot touch phases
  logic              touch_en = 1'b1;
  logic [FieldW-1:0] irq_mask = '0;
  logic [PosW-1:0]   max_x = '1;
  logic [PosW-1:0]   max_y = '1;
  logic [1:0]        slot_phase [NumSlots];

  finger_rec_t    pending [$];
  finger_report_t report_q [$];

  logic idle_en = 1'b0;
  int   hold_ticket = 0;
  int   hold_seen = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   quiet = 0;
  int   errors = 0;

  int n_records = 0, n_ignored = 0, n_reports = 0;
  int n_contact = 0, n_release = 0, n_frame_end = 0, n_clamped = 0;

  always #5 clk_i = ~clk_i;

  multitouch_finger_report_decoder #(
    .MAX_FINGERS(NumSlots)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .interrupt_status_i(rec_drv.intr),
    .finger_index_i    (rec_drv.idx),
    .finger_status_i   (rec_drv.status),
    .x_high_i          (rec_drv.x_high),
    .y_high_i          (rec_drv.y_high),
    .xy_low_i          (rec_drv.xy_low),
    .width_pair_i      (rec_drv.width_pair),
    .pressure_i        (rec_drv.pressure),
    .last_finger_i     (rec_drv.last_finger),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .has_contact_o     (has_contact_o),
    .tracking_id_o     (tracking_id_o),
    .contact_pressure_o(contact_pressure_o),
    .contact_width_o   (contact_width_o),
    .position_x_o      (position_x_o),
    .position_y_o      (position_y_o),
    .frame_end_o       (frame_end_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  function automatic logic [PosW-1:0] offset_clamp(input logic [PosW-1:0] raw,
                                                   input logic [PosW-1:0] lim);
    logic [PosW-1:0] v;
    if (raw < PosOffset) return '0;
    v = raw - PosOffset;
    if (v > lim) begin
      n_clamped++;
      return lim;
    end
    return v;
  endfunction

  function automatic void decode_record(input finger_rec_t r);
    logic [1:0]     ph;
    logic           contact;
    finger_report_t rep;
    contact = 1'b0;
    n_records++;
    if (!touch_en || (r.intr & irq_mask) == '0) begin
      n_ignored++;
      return;
    end
    if (r.idx < NumSlots) begin
      ph = slot_phase[r.idx];
      if (r.status == StatusPresent) ph = PhaseTouch;
      else if (r.status == StatusAbsent && ph != PhaseIdle) ph = PhaseRelease;
      if (ph == PhaseRelease) begin
        ph = PhaseIdle;
        contact = 1'b1;
        n_release++;
      end else if (ph == PhaseTouch) begin
        contact = 1'b1;
      end
      slot_phase[r.idx] = ph;
    end
    if (!contact && !r.last_finger) return;
    rep = '0;
    if (contact) begin
      n_contact++;
      rep.has_contact = 1'b1;
      rep.tracking_id = r.idx;
      rep.pressure    = r.pressure;
      rep.width       = {1'b0, r.width_pair[3:0]} + {1'b0, r.width_pair[7:4]};
      rep.pos_x       = offset_clamp({r.x_high, r.xy_low[3:0]}, max_x);
      rep.pos_y       = offset_clamp({r.y_high, r.xy_low[7:4]}, max_y);
    end
    if (r.last_finger) n_frame_end++;
    rep.frame_end = r.last_finger;
    report_q.push_back(rep);
  endfunction

  function automatic void check_field(input string name, input int exp, input int got);
    if (exp != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp, got);
      errors++;
    end
  endfunction

  // driver: one record per beat, random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) decode_record(rec_drv);
      if (!in_valid || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          rec_drv  <= pending.pop_front();
          in_valid <= 1'b1;
          if (idle_en && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and report checker
  always @(posedge clk_i or negedge rst_ni) begin
    finger_report_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        n_reports++;
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report, expected none, got slot %0d frame_end %0b",
                   $realtime, tracking_id_o, frame_end_o);
          errors++;
        end else begin
          want = report_q.pop_front();
          check_field("has_contact", want.has_contact, has_contact_o);
          check_field("tracking_id", want.tracking_id, tracking_id_o);
          check_field("contact_pressure", want.pressure, contact_pressure_o);
          check_field("contact_width", want.width, contact_width_o);
          check_field("position_x", want.pos_x, position_x_o);
          check_field("position_y", want.pos_y, position_y_o);
          check_field("frame_end", want.frame_end, frame_end_o);
        end
      end
      if (hold_ticket != hold_seen) begin
        hold_seen  = hold_ticket;
        stall_left = LongHold;
      end else if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t: no beat for %0d cycles", $realtime, QuietLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic void add_rec(input logic [7:0] intr, input logic [3:0] idx,
                                  input logic [1:0] status, input logic [7:0] xh,
                                  input logic [7:0] yh, input logic [7:0] xyl,
                                  input logic [7:0] wp, input logic [7:0] z,
                                  input logic last_finger);
    pending.push_back('{intr, idx, status, xh, yh, xyl, wp, z, last_finger});
  endfunction

  function automatic finger_rec_t noise_rec();
    finger_rec_t r;
    r.intr        = FieldW'($urandom_range(0, 255));
    r.idx         = IndexW'($urandom_range(0, 15));
    r.status      = 2'($urandom_range(0, 3));
    r.x_high      = FieldW'($urandom_range(0, 255));
    r.y_high      = FieldW'($urandom_range(0, 255));
    r.xy_low      = FieldW'($urandom_range(0, 255));
    r.width_pair  = FieldW'($urandom_range(0, 255));
    r.pressure    = FieldW'($urandom_range(0, 255));
    r.last_finger = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed frames hitting the mask, with noise records in between
  function automatic void gen_traffic(input int target);
    int          made;
    int          nf;
    int          first;
    int          sel;
    logic [7:0]  intr;
    logic        drop_last;
    finger_rec_t r;
    made = 0;
    while (made < target) begin
      if ($urandom_range(0, 7) == 0) begin
        pending.push_back(noise_rec());
        made++;
      end else begin
        do intr = 8'($urandom_range(0, 255)); while ((intr & irq_mask) == '0);
        nf        = $urandom_range(1, NumSlots);
        first     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NumSlots - 1) : 0;
        drop_last = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < nf; k++) begin
          r        = noise_rec();
          r.intr   = intr;
          r.idx    = IndexW'((first + k) % NumSlots);
          r.x_high = edgy_byte();
          r.y_high = edgy_byte();
          sel      = $urandom_range(0, 19);
          if (sel < 11) r.status = StatusPresent;
          else if (sel < 16) r.status = StatusAbsent;
          else r.status = 2'($urandom_range(2, 3));
          r.last_finger = (k == nf - 1) && !drop_last;
          pending.push_back(r);
        end
        made += nf;
      end
    end
  endfunction

  function automatic void gen_noise(input int count);
    repeat (count) pending.push_back(noise_rec());
  endfunction

  task automatic drain();
    while (pending.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic en, input logic [7:0] mask,
                            input logic [11:0] mx, input logic [11:0] my);
    write_reg(CfgTouchPresent, {11'd0, en});
    write_reg(CfgIntrMask, {4'd0, mask});
    write_reg(CfgMaxX, mx);
    write_reg(CfgMaxY, my);
    cfg_we_i  <= 1'b0;
    touch_en  = en;
    irq_mask  = mask;
    max_x     = mx;
    max_y     = my;
  endtask

  initial begin
    foreach (slot_phase[k]) slot_phase[k] = PhaseIdle;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(1'b1, 8'hFF, 12'hFFF, 12'hFFF);
    // touch at the low corner, then all-ones payload
    add_rec(8'hFF, 4'd0, StatusPresent, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_rec(8'hFF, 4'd0, StatusPresent, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    // other status keeps a touching finger reporting, partial mask hits
    add_rec(8'h01, 4'd0, 2'd2, 8'h40, 8'h80, 8'h3C, 8'h12, 8'h33, 1'b0);
    add_rec(8'h80, 4'd0, 2'd3, 8'h41, 8'h81, 8'hC3, 8'h21, 8'h44, 1'b0);
    // release report, then nothing while idle until the frame end
    add_rec(8'hFF, 4'd0, StatusAbsent, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 1'b0);
    add_rec(8'hFF, 4'd0, StatusAbsent, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 1'b0);
    add_rec(8'hFF, 4'd0, 2'd2, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 1'b0);
    add_rec(8'hFF, 4'd0, 2'd2, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 1'b1);
    // raw position just at, above and below the offset on the top slot
    add_rec(8'hFF, 4'd9, StatusPresent, 8'h00, 8'h00, 8'h66, 8'h0F, 8'h10, 1'b1);
    add_rec(8'hFF, 4'd9, StatusPresent, 8'h00, 8'h00, 8'h77, 8'hF0, 8'h20, 1'b0);
    add_rec(8'hFF, 4'd9, StatusPresent, 8'h00, 8'h00, 8'h55, 8'hF5, 8'h30, 1'b0);
    add_rec(8'hFF, 4'd9, StatusAbsent, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 1'b1);
    // slots past the end: silent, or frame end only
    add_rec(8'hFF, 4'd10, StatusPresent, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 1'b0);
    add_rec(8'hFF, 4'd15, StatusPresent, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 1'b1);
    // mask miss leaves no state behind, even on a frame's last record
    add_rec(8'h00, 4'd3, StatusPresent, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 1'b1);
    add_rec(8'hFF, 4'd3, StatusAbsent, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 1'b0);
    add_rec(8'hFF, 4'd5, StatusPresent, 8'hAA, 8'h55, 8'hA5, 8'h5A, 8'hC3, 1'b0);
    add_rec(8'hFF, 4'd5, StatusPresent, 8'h55, 8'hAA, 8'h5A, 8'hA5, 8'h3C, 1'b1);
    add_rec(8'hFF, 4'd5, StatusAbsent, 8'hFF, 8'h00, 8'hF0, 8'h0F, 8'h00, 1'b1);
    drain();

    idle_en <= 1'b1;
    gen_traffic(300);
    while (pending.size() > 150) @(posedge clk_i);
    // long receiver hold while the sender keeps offering
    hold_ticket <= hold_ticket + 1;
    drain();

    set_config(1'b1, 8'h04, 12'd100, 12'd3000);
    gen_traffic(100);
    drain();
    gen_traffic(100);
    drain();

    set_config(1'b0, 8'hFF, 12'd2048, 12'd1);
    gen_noise(20);
    drain();
    set_config(1'b1, 8'h00, 12'd4095, 12'd0);
    gen_noise(20);
    drain();

    set_config(1'b1, 8'hF0, 12'd0, 12'd0);
    gen_traffic(100);
    drain();

    idle_en <= 1'b0;
    set_config(1'b1, 8'h21, 12'hFFF, 12'hFFF);
    gen_traffic(160);
    drain();
    repeat (10) @(posedge clk_i);

    if (report_q.size() != 0) begin
      $display("%0t: %0d reports never arrived", $realtime, report_q.size());
      errors++;
    end
    $display("run: %0d records (%0d ignored), %0d reports checked, %0d errors",
             n_records, n_ignored, n_reports, errors);
    $display("     %0d contacts, %0d releases, %0d frame ends, %0d clamped positions",
             n_contact, n_release, n_frame_end, n_clamped);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mtfrd_pkg.sv
sv/mtfrd_front.sv
sv/mtfrd_queue.sv
sv/mtfrd_back.sv
sv/multitouch_finger_report_decoder.sv
tb/tb.sv
